### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the bisection square root block.
// Checks compile in simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

### rtl/core/bsqrt_pkg.sv
// Constants and widths for the bisection square root block.
// No dependencies.
`default_nettype none

package bsqrt_pkg;

    localparam int MAX_ITERATIONS = 48;
    localparam int FRACTION_BITS  = 16;

    localparam int VALUE_W = 32;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int COUNT_W = 7;
    localparam int STEP_W  = $clog2(MAX_ITERATIONS + 1);
    localparam int STATE_W = 3;

    localparam logic [VALUE_W-1:0] ONE         = VALUE_W'(1) << FRACTION_BITS;
    localparam logic [STEP_W-1:0]  STEP_LIMIT  = STEP_W'(MAX_ITERATIONS);
    localparam logic [COUNT_W-1:0] LIMIT_COUNT = COUNT_W'(MAX_ITERATIONS + 1);

endpackage

`default_nettype wire

### rtl/core/bisection_square_root_top.sv
// Bisection square root of an unsigned fixed-point value, one shared multiplier.
// Depends on bsqrt_pkg and assert_macros.svh.
//
// Takes one unsigned Q16.16 request at a time and returns its root, the number
// of approximations and a limit flag. The search interval [0, max(1, value)]
// is halved until |x*x - value| is within epsilon, compared at Q32.32. Each
// halving uses two states: the 32x32 squaring on the shared multiplier, then
// the compare and the interval update. A finished result waits for the output
// side until the result register is free. in_stall stays high from acceptance
// until the result is loaded; the result register then holds it while the next
// request is worked on. epsilon resets to 66 and is written through the cfg
// channel.
`default_nettype none

`include "assert_macros.svh"

module bisection_square_root_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bsqrt_pkg::VALUE_W-1:0]      cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bsqrt_pkg::VALUE_W-1:0]      value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bsqrt_pkg::VALUE_W-1:0]           root,
    output logic [bsqrt_pkg::COUNT_W-1:0]           approximations,
    output logic                                    limit_hit
);

    localparam logic [bsqrt_pkg::STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [bsqrt_pkg::STATE_W-1:0] ST_SQ_HI  = 3'd1;
    localparam logic [bsqrt_pkg::STATE_W-1:0] ST_CHK_HI = 3'd2;
    localparam logic [bsqrt_pkg::STATE_W-1:0] ST_SQ_X   = 3'd3;
    localparam logic [bsqrt_pkg::STATE_W-1:0] ST_EVAL   = 3'd4;

    logic [bsqrt_pkg::STATE_W-1:0] state_reg, state_next;
    logic [bsqrt_pkg::STEP_W-1:0]  steps_reg, steps_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bsqrt_pkg::VALUE_W-1:0] epsilon_reg, epsilon_next;

    logic [bsqrt_pkg::VALUE_W-1:0] v_reg, v_next;
    logic [bsqrt_pkg::VALUE_W-1:0] lo_reg, lo_next;
    logic [bsqrt_pkg::VALUE_W-1:0] hi_reg, hi_next;
    logic [bsqrt_pkg::VALUE_W-1:0] x_reg, x_next;
    logic [bsqrt_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [bsqrt_pkg::VALUE_W-1:0] root_reg, root_next;
    logic [bsqrt_pkg::COUNT_W-1:0] approx_reg, approx_next;
    logic                          hit_reg, hit_next;

    logic                          out_free;
    logic [bsqrt_pkg::VALUE_W-1:0] mult_op;
    logic [bsqrt_pkg::PROD_W-1:0]  square;
    logic [bsqrt_pkg::PROD_W-1:0]  target;
    logic [bsqrt_pkg::PROD_W-1:0]  tol;
    logic [bsqrt_pkg::PROD_W-1:0]  diff;
    logic                          below;
    logic [bsqrt_pkg::VALUE_W:0]   sum_up;
    logic [bsqrt_pkg::VALUE_W:0]   sum_down;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign approximations = approx_reg;
    assign limit_hit      = hit_reg;

    // Shared squaring unit: upper end first, then each midpoint
    assign mult_op = (state_reg == ST_SQ_HI) ? hi_reg : x_reg;
    assign square  = bsqrt_pkg::PROD_W'(mult_op) * bsqrt_pkg::PROD_W'(mult_op);

    assign target = bsqrt_pkg::PROD_W'(v_reg) << bsqrt_pkg::FRACTION_BITS;
    assign tol    = bsqrt_pkg::PROD_W'(epsilon_reg) << bsqrt_pkg::FRACTION_BITS;
    assign below  = (prod_reg < target);
    assign diff   = below ? (target - prod_reg) : (prod_reg - target);

    // Both candidate midpoints in parallel with the compare
    assign sum_up   = {1'b0, x_reg} + {1'b0, hi_reg};
    assign sum_down = {1'b0, lo_reg} + {1'b0, x_reg};

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        epsilon_next   = epsilon_reg;
        out_valid_next = out_valid_reg && out_stall;
        v_next         = v_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        root_next      = root_reg;
        approx_next    = approx_reg;
        hit_next       = hit_reg;

        if (cfg_valid && cfg_ready)
        begin
            epsilon_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = value;
                    lo_next    = '0;
                    hi_next    = (value < bsqrt_pkg::ONE) ? bsqrt_pkg::ONE : value;
                    steps_next = '0;
                    state_next = ST_SQ_HI;
                end
            end
            ST_SQ_HI:
            begin
                prod_next  = square;
                state_next = ST_CHK_HI;
            end
            ST_CHK_HI:
            begin
                if ((v_reg == '0) || (prod_reg == target))
                begin
                    // exact endpoint: hold until the result register frees up
                    if (out_free)
                    begin
                        root_next      = (v_reg == '0) ? '0 : hi_reg;
                        approx_next    = '0;
                        hit_next       = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    x_next     = hi_reg >> 1;
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                prod_next  = square;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if ((diff <= tol) || (steps_reg >= bsqrt_pkg::STEP_LIMIT))
                begin
                    if (out_free)
                    begin
                        root_next      = x_reg;
                        approx_next    = bsqrt_pkg::COUNT_W'(steps_reg) + 1'b1;
                        hit_next       = (diff > tol);
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (below)
                    begin
                        lo_next = x_reg;
                        x_next  = sum_up[bsqrt_pkg::VALUE_W:1];
                    end
                    else
                    begin
                        hi_next = x_reg;
                        x_next  = sum_down[bsqrt_pkg::VALUE_W:1];
                    end
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_SQ_X;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
            epsilon_reg   <= bsqrt_pkg::VALUE_W'(66);
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            epsilon_reg   <= epsilon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        x_reg      <= x_next;
        prod_reg   <= prod_next;
        root_reg   <= root_next;
        approx_reg <= approx_next;
        hit_reg    <= hit_next;
    end

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
        "request accepted but input not stalled")
    `ASSERT_ALWAYS(a_bracket, clk, rst_n,
        (state_reg != ST_EVAL) || ((lo_reg <= x_reg) && (x_reg <= hi_reg)),
        "midpoint left the search interval")
    `ASSERT_ALWAYS(a_count_range, clk, rst_n,
        !out_valid_reg || (approx_reg <= bsqrt_pkg::LIMIT_COUNT),
        "approximation count beyond limit")
    `ASSERT_ALWAYS(a_limit_count, clk, rst_n,
        !(out_valid_reg && hit_reg) || (approx_reg == bsqrt_pkg::LIMIT_COUNT),
        "limit flag without full count")

endmodule

`default_nettype wire

### dv/tb_bisection_square_root_top.sv
// Self-checking testbench for bisection_square_root_top: a directed table, then random phases.
// Every phase runs under its own epsilon, and every result is checked against the directed table or a local predictor.
// Depends on bsqrt_pkg and the RTL of the block.
`default_nettype none

module tb_bisection_square_root_top;

    localparam int VW = bsqrt_pkg::VALUE_W;
    localparam int CW = bsqrt_pkg::COUNT_W;
    localparam int FRAC = bsqrt_pkg::FRACTION_BITS;
    localparam int HALVING_LIMIT = bsqrt_pkg::MAX_ITERATIONS;
    localparam logic [VW-1:0] UNIT = bsqrt_pkg::ONE;
    localparam logic [VW-1:0] EPS_AT_RESET = 32'd66;
    localparam logic [VW-1:0] EPS_MAX = 32'hFFFF_FFFF;

    localparam int ROW_COUNT = 24;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int TAIL_CYCLES = 120;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [VW-1:0] root;
        logic [CW-1:0] count;
        logic          hit;
    } root_result_t;

    typedef struct packed {
        logic [VW-1:0] arg;
        root_result_t  res;
    } root_request_t;

    typedef struct packed {
        logic [VW-1:0] eps;
        logic [VW-1:0] arg;
        logic          known;
        logic [VW-1:0] root;
        logic [CW-1:0] count;
        logic          hit;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [VW-1:0] cfg_data;
    logic          in_valid;
    logic          in_stall;
    logic [VW-1:0] value;
    logic          out_valid;
    logic          out_stall;
    logic [VW-1:0] root;
    logic [CW-1:0] approximations;
    logic          limit_hit;

    root_request_t pending_roots [$];
    stim_row_t     directed_rows [ROW_COUNT];
    logic [VW-1:0] epsilon_now;
    int            bad_results;
    int            cycle_count;
    int            next_gap;
    bit            send_burst;
    bit            recv_burst;

    bisection_square_root_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .root           (root),
        .approximations (approximations),
        .limit_hit      (limit_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bisection at double fraction width, same truncating midpoint as the block.
    function automatic root_result_t predict_root(input logic [VW-1:0] v,
                                                  input logic [VW-1:0] eps);
        logic [63:0]  target;
        logic [63:0]  tol;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  x;
        logic [63:0]  sq;
        logic [63:0]  gap;
        int           steps;
        logic         hit;
        root_result_t r;
        target = {32'd0, v} << FRAC;
        tol    = {32'd0, eps} << FRAC;
        lo     = 64'd0;
        hi     = (v < UNIT) ? {32'd0, UNIT} : {32'd0, v};
        steps  = 0;
        hit    = 1'b0;
        r      = '0;
        if (v == '0)
            return r;
        if (hi * hi == target)
        begin
            r.root = hi[VW-1:0];
            return r;
        end
        x  = (lo + hi) >> 1;
        sq = x * x;
        gap = (sq >= target) ? sq - target : target - sq;
        while (gap > tol)
        begin
            if (steps >= HALVING_LIMIT)
            begin
                hit = 1'b1;
                break;
            end
            if (sq < target)
                lo = x;
            else
                hi = x;
            x   = (lo + hi) >> 1;
            sq  = x * x;
            gap = (sq >= target) ? sq - target : target - sq;
            steps++;
        end
        r.root  = x[VW-1:0];
        r.count = CW'(steps + 1);
        r.hit   = hit;
        return r;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] m;
        case ($urandom_range(0, 9))
            4: return VW'($urandom_range(0, 32'h0000_FFFF));
            5:
            begin
                // exact squares, whose roots have at most eight fraction bits
                m = VW'($urandom_range(0, 32'h0000_FFFF));
                return m * m;
            end
            6:
            begin
                m = VW'($urandom_range(0, 255));
                return (m * m) << FRAC;
            end
            7:
            begin
                case ($urandom_range(0, 6))
                    0: return '0;
                    1: return VW'(1);
                    2: return UNIT;
                    3: return UNIT - 1;
                    4: return UNIT + 1;
                    5: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            8: return $urandom >> $urandom_range(0, 31);
            9: return UNIT + VW'($urandom_range(0, 64)) - 32;
            default: return $urandom;
        endcase
    endfunction

    // Wait out the drawn gap, offer the request, hold it until in_stall is seen low.
    task automatic push_value(input logic [VW-1:0] v, input root_result_t want, input bit last);
        root_request_t req;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        req.arg = v;
        req.res = want;
        pending_roots.push_back(req);
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        next_gap = draw_wait(send_burst);
        // keep valid high only when the next request follows back to back
        if (last || next_gap != 0)
            in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_roots.size() != 0) @(posedge clk);
    endtask

    task automatic load_epsilon(input logic [VW-1:0] e);
        cfg_valid <= 1'b1;
        cfg_data  <= e;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        epsilon_now = e;
    endtask

    initial
    begin : result_side
        int            stall_left;
        root_result_t  got;
        root_request_t req;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.root  = root;
                got.count = approximations;
                got.hit   = limit_hit;
                if (pending_roots.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("unexpected result: root %h approximations %0d limit_hit %0b",
                                 got.root, got.count, got.hit);
                    bad_results++;
                end
                else
                begin
                    req = pending_roots.pop_front();
                    if (got.root !== req.res.root || got.count !== req.res.count ||
                        got.hit !== req.res.hit)
                    begin
                        if (bad_results < 10)
                        begin
                            $display("mismatch for value %h: expected root %h approximations %0d",
                                     req.arg, req.res.root, req.res.count);
                            $display("  limit_hit %0b, got root %h approximations %0d limit_hit %0b",
                                     req.res.hit, got.root, got.count, got.hit);
                        end
                        bad_results++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                stall_left = draw_wait(recv_burst);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        root_result_t  want;
        logic [VW-1:0] eps_next;
        bit            last;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        value       = '0;
        bad_results = 0;
        next_gap    = 0;
        send_burst  = 1'b0;
        recv_burst  = 1'b0;
        epsilon_now = EPS_AT_RESET;

        // eps, value, known, root, approximations, limit_hit
        directed_rows = '{
            '{EPS_AT_RESET, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0001_0000, 1'b1, 32'h0001_0000, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0004_0000, 1'b1, 32'h0002_0000, 7'd1, 1'b0},
            '{EPS_AT_RESET, 32'h0000_0001, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0000_FFFF, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0001_0001, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0002_0000, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'hFFFF_FFFF, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h8000_0000, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'hAAAA_AAAA, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h5555_5555, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_AT_RESET, 32'h0009_0000, 1'b0, 32'h0, 7'd0, 1'b0},
            '{32'h0, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, 1'b0},
            '{32'h0, 32'h0001_0000, 1'b1, 32'h0001_0000, 7'd0, 1'b0},
            '{32'h0, 32'h0002_0000, 1'b0, 32'h0, 7'd0, 1'b0},
            '{32'h0, 32'h0000_0001, 1'b0, 32'h0, 7'd0, 1'b0},
            '{32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 7'd0, 1'b0},
            '{32'h0, 32'h0000_0004, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_MAX, 32'h0002_0000, 1'b1, 32'h0001_0000, 7'd1, 1'b0},
            '{EPS_MAX, 32'h0000_0001, 1'b1, 32'h0000_8000, 7'd1, 1'b0},
            '{EPS_MAX, 32'hFFFF_FFFF, 1'b0, 32'h0, 7'd0, 1'b0},
            '{EPS_MAX, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd0, 1'b0},
            '{32'h1, 32'h0003_0000, 1'b0, 32'h0, 7'd0, 1'b0},
            '{32'h1, 32'h7FFF_FFFF, 1'b0, 32'h0, 7'd0, 1'b0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (directed_rows[r].eps != epsilon_now)
            begin
                wait_drained();
                load_epsilon(directed_rows[r].eps);
            end
            if (directed_rows[r].known)
            begin
                want.root  = directed_rows[r].root;
                want.count = directed_rows[r].count;
                want.hit   = directed_rows[r].hit;
            end
            else
                want = predict_root(directed_rows[r].arg, epsilon_now);
            last = (r == ROW_COUNT - 1) || (directed_rows[r + 1].eps != directed_rows[r].eps);
            push_value(directed_rows[r].arg, want, last);
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: eps_next = VW'($urandom_range(0, 255));
                1: eps_next = '0;
                2: eps_next = $urandom;
                3: eps_next = EPS_MAX;
                4: eps_next = $urandom >> $urandom_range(0, 31);
                5: eps_next = EPS_AT_RESET;
                default: eps_next = 32'd1;
            endcase
            load_epsilon(eps_next);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // now and then hold off until the block has emptied
                last = (i == PHASE_ITEMS - 1) || ($urandom_range(0, 63) == 0);
                value_pick : begin
                    logic [VW-1:0] v;
                    v = pick_value();
                    push_value(v, predict_root(v, epsilon_now), last);
                end
                if (last)
                    wait_drained();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_results == 0 && pending_roots.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/bsqrt_pkg.sv
rtl/core/bisection_square_root_top.sv
dv/tb_bisection_square_root_top.sv
